>>> design/stt_pkg.sv
package stt_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned TICK_W          = 32;
  localparam int unsigned CB_W            = 8;
  localparam int unsigned TAG_W           = 32;
  localparam int unsigned DUR_W           = 32;
  localparam int unsigned MPT_W           = 16;
  localparam logic [MPT_W-1:0] MPT_RESET  = 16'd10;

  typedef enum logic [1:0] {
    RK_STORED  = 2'd0,
    RK_FIRED   = 2'd1,
    RK_DROPPED = 2'd2,
    RK_EXPIRED = 2'd3
  } result_kind_t;

  // One timer as held in a cell of the chain
  typedef struct packed {
    logic              valid;
    logic              pend;
    logic [TICK_W-1:0] ticks;
    logic [CB_W-1:0]   cb;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic insert;
    logic rotate;
    logic start_tick;
  } cell_ctrl_t;

endpackage

>>> design/stt_ifs.sv
interface stt_in_if;
  import stt_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [CB_W-1:0]  callback_id;
  logic [TAG_W-1:0] tag;
  logic [DUR_W-1:0] duration;
  modport source (output valid, kind, callback_id, tag, duration, input ready);
  modport sink   (input valid, kind, callback_id, tag, duration, output ready);
endinterface

interface stt_out_if;
  import stt_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       result_kind;
  logic [CB_W-1:0]  fired_callback;
  logic [TAG_W-1:0] fired_tag;
  logic             last;
  modport source (output valid, result_kind, fired_callback, fired_tag, last, input ready);
  modport sink   (input valid, result_kind, fired_callback, fired_tag, last, output ready);
endinterface

interface stt_cfg_if;
  import stt_pkg::*;
  logic             valid;
  logic             ready;
  logic [MPT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/stt_cell.sv
module stt_cell
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       shift_en,
  input  entry_t     prev_in,
  input  entry_t     next_in,
  output entry_t     q,
  output logic       expiring
);

  entry_t ent_r;
  entry_t ent_nxt;
  entry_t ent_rst;

  // Pick the next content: insert shift, tick rotation or tick start
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.insert && shift_en) begin
      ent_nxt = prev_in;
    end else if (ctrl.rotate) begin
      ent_nxt = next_in;
    end else if (ctrl.start_tick) begin
      ent_nxt.pend = ent_r.valid;
    end
  end

  // Clear the flags on reset, keep the payload
  always_comb begin
    ent_rst       = ent_nxt;
    ent_rst.valid = 1'b0;
    ent_rst.pend  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= ent_rst;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign q        = ent_r;
  // Count of one or zero reaches zero on this tick
  assign expiring = ent_r.valid && (ent_r.ticks[TICK_W-1:1] == '0);

endmodule

>>> design/stt_divider.sv
module stt_divider
  import stt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DUR_W-1:0]  dividend,
  input  logic [MPT_W-1:0]  divisor,
  output logic              done,
  output logic [DUR_W-1:0]  quotient
);

  localparam int unsigned CNT_W = $clog2(DUR_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MPT_W-1:0] rem_r, rem_nxt;
  logic [DUR_W-1:0] quo_r, quo_nxt;
  logic [MPT_W-1:0] div_r, div_nxt;
  logic [MPT_W:0]   trial;
  logic [MPT_W:0]   diff;

  assign trial = {rem_r, quo_r[DUR_W-1]};
  assign diff  = trial - {1'b0, div_r};

  // One quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = (divisor == '0) ? MPT_W'(1) : divisor;
    end else if (busy_r) begin
      if (!diff[MPT_W]) begin
        rem_nxt = diff[MPT_W-1:0];
        quo_nxt = {quo_r[DUR_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[MPT_W-1:0];
        quo_nxt = {quo_r[DUR_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DUR_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = busy_r && !busy_nxt;
  assign quotient = quo_nxt;

endmodule

>>> design/software_timer_table.sv
// Table of one-shot software timers held in a chain of cells ordered by age,
// newest in the first cell. An add request with zero duration answers
// "fired" at once; with the table full it answers "dropped"; otherwise the
// duration is divided by micros_per_tick in a bit-serial divider and the
// timer is pushed into the chain, after which the "stored" result is
// registered. A tick request rotates the whole chain once through its head,
// one cell per cycle while the result channel is not stalled; each expiring
// timer is reported as it passes the head, newest first, with last set on
// the final one. A tick that expires nothing gives no result. One request is
// worked on at a time; a finished result waits in the output register while
// the next request is taken.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  stt_in_if.sink    in_if,
  stt_out_if.source out_if,
  stt_cfg_if.sink   cfg_if
);

  localparam int unsigned CNT_W = $clog2(TIMER_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_PUSH = 4'b0100,
    S_TICK = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MPT_W-1:0] mpt_r;

  // Pending add payload and pending single result
  logic [CB_W-1:0]  add_cb_r, add_cb_nxt;
  logic [TAG_W-1:0] add_tag_r, add_tag_nxt;
  logic [1:0]       res_kind_r, res_kind_nxt;
  logic [CB_W-1:0]  res_cb_r, res_cb_nxt;
  logic [TAG_W-1:0] res_tag_r, res_tag_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [CB_W-1:0]  out_cb_r, out_cb_nxt;
  logic [TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;

  logic             in_acc;
  logic             div_start, div_done;
  logic [DUR_W-1:0] quotient;

  cell_ctrl_t       ctrl;
  entry_t           cells   [TIMER_SLOTS];
  entry_t           prev_in [TIMER_SLOTS];
  entry_t           next_in [TIMER_SLOTS];
  logic             shift_en[TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] exp_v, valid_v, later_exp;
  entry_t           new_ent, tail_ent;
  logic             full, tick_step, head_exp, tick_last;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  // Configuration register
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r <= MPT_RESET;
    end else if (cfg_if.valid) begin
      mpt_r <= cfg_if.data;
    end
  end

  stt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_if.duration),
    .divisor  (mpt_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Chain wiring
  always_comb begin
    new_ent       = '0;
    new_ent.valid = 1'b1;
    new_ent.ticks = quotient;
    new_ent.cb    = add_cb_r;
    new_ent.tag   = add_tag_r;
    tail_ent       = cells[0];
    tail_ent.valid = cells[0].valid && !head_exp;
    tail_ent.pend  = 1'b0;
    tail_ent.ticks = cells[0].ticks - 1'b1;
  end

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_in[i]  = new_ent;
      assign shift_en[i] = 1'b1;
    end else begin : g_body
      assign prev_in[i]  = cells[i-1];
      assign shift_en[i] = shift_en[i-1] && cells[i-1].valid;
    end
    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign next_in[i] = tail_ent;
    end else begin : g_mid
      assign next_in[i] = cells[i+1];
    end
    assign valid_v[i]   = cells[i].valid;
    assign later_exp[i] = (i != 0) && exp_v[i] && cells[i].pend;

    stt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .shift_en (shift_en[i]),
      .prev_in  (prev_in[i]),
      .next_in  (next_in[i]),
      .q        (cells[i]),
      .expiring (exp_v[i])
    );
  end

  assign full      = &valid_v;
  assign head_exp  = exp_v[0];
  assign tick_step = (state_r == S_TICK) && out_free;
  assign tick_last = !(|later_exp);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    add_cb_nxt   = add_cb_r;
    add_tag_nxt  = add_tag_r;
    res_kind_nxt = res_kind_r;
    res_cb_nxt   = res_cb_r;
    res_tag_nxt  = res_tag_r;
    div_start    = 1'b0;
    ctrl         = '0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt  = out_kind_r;
    out_cb_nxt    = out_cb_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_if.kind) begin
            ctrl.start_tick = 1'b1;
            cnt_nxt         = '0;
            state_nxt       = S_TICK;
          end else if (in_if.duration == '0) begin
            res_kind_nxt = RK_FIRED;
            res_cb_nxt   = in_if.callback_id;
            res_tag_nxt  = in_if.tag;
            state_nxt    = S_PUSH;
          end else if (full) begin
            res_kind_nxt = RK_DROPPED;
            res_cb_nxt   = '0;
            res_tag_nxt  = '0;
            state_nxt    = S_PUSH;
          end else begin
            add_cb_nxt  = in_if.callback_id;
            add_tag_nxt = in_if.tag;
            div_start   = 1'b1;
            state_nxt   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          ctrl.insert  = 1'b1;
          res_kind_nxt = RK_STORED;
          res_cb_nxt   = '0;
          res_tag_nxt  = '0;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_cb_nxt    = res_cb_r;
          out_tag_nxt   = res_tag_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TICK: begin
        if (tick_step) begin
          ctrl.rotate = 1'b1;
          if (head_exp) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = RK_EXPIRED;
            out_cb_nxt    = cells[0].cb;
            out_tag_nxt   = cells[0].tag;
            out_last_nxt  = tick_last;
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(TIMER_SLOTS - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    add_cb_r   <= add_cb_nxt;
    add_tag_r  <= add_tag_nxt;
    res_kind_r <= res_kind_nxt;
    res_cb_r   <= res_cb_nxt;
    res_tag_r  <= res_tag_nxt;
    out_kind_r <= out_kind_nxt;
    out_cb_r   <= out_cb_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_if.ready           = (state_r == S_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.result_kind    = out_kind_r;
  assign out_if.fired_callback = out_cb_r;
  assign out_if.fired_tag      = out_tag_r;
  assign out_if.last           = out_last_r;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import stt_pkg::*;

  localparam int SLOTS       = TIMER_SLOTS_DEF;
  localparam int SETTLE      = 60;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    result_kind_t kind;
    logic [CB_W-1:0]  cb;
    logic [TAG_W-1:0] tag;
    logic             last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();
  stt_cfg_if cfg_ch ();

  software_timer_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Shadow copy of the timer table
  logic [MPT_W-1:0]  tick_div;
  logic              tmr_active [SLOTS];
  logic signed [33:0] tmr_left  [SLOTS];
  logic [CB_W-1:0]   tmr_cb     [SLOTS];
  logic [TAG_W-1:0]  tmr_tag    [SLOTS];
  int                tmr_age    [SLOTS];

  timer_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_expired = 0;
  int n_dropped = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic timer_result_t make_result(result_kind_t k, logic [CB_W-1:0] cb,
                                                logic [TAG_W-1:0] tg, logic lst);
    timer_result_t r;
    r.kind = k;
    r.cb = cb;
    r.tag = tg;
    r.last = lst;
    return r;
  endfunction

  // Work out the results of one accepted request and advance the table
  task automatic predict_timers(input logic kind, input logic [CB_W-1:0] cb,
                                input logic [TAG_W-1:0] tg, input logic [DUR_W-1:0] dur);
    logic [DUR_W-1:0] div;
    int free_slot;
    int count;
    int n;
    int new_age [SLOTS];
    logic gone [SLOTS];
    free_slot = -1;
    count = 0;
    n = 0;
    div = (tick_div == '0) ? 1 : DUR_W'(tick_div);
    if (kind == 1'b0) begin
      if (dur == '0) begin
        pending_results.push_back(make_result(RK_FIRED, cb, tg, 1'b1));
        return;
      end
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!tmr_active[i]) free_slot = i;
      if (free_slot < 0) begin
        pending_results.push_back(make_result(RK_DROPPED, '0, '0, 1'b1));
        n_dropped++;
        return;
      end
      for (int i = 0; i < SLOTS; i++)
        if (tmr_active[i]) tmr_age[i]++;
      tmr_active[free_slot] = 1'b1;
      tmr_left[free_slot] = $signed({2'b00, dur / div});
      tmr_cb[free_slot] = cb;
      tmr_tag[free_slot] = tg;
      tmr_age[free_slot] = 0;
      pending_results.push_back(make_result(RK_STORED, '0, '0, 1'b1));
      return;
    end
    // Tick: walk newest to oldest, decrement, report each expiry
    for (int i = 0; i < SLOTS; i++) begin
      gone[i] = 1'b0;
      if (tmr_active[i]) count++;
    end
    for (int a = 0; a < count; a++) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (tmr_active[i] && tmr_age[i] == a) begin
          tmr_left[i] = tmr_left[i] - 1;
          if (tmr_left[i] <= 0) begin
            gone[i] = 1'b1;
            pending_results.push_back(make_result(RK_EXPIRED, tmr_cb[i], tmr_tag[i], 1'b0));
            n++;
            n_expired++;
          end
          break;
        end
      end
    end
    if (n == 0) return;
    pending_results[$].last = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      new_age[i] = 0;
      for (int j = 0; j < SLOTS; j++)
        if (tmr_active[j] && !gone[j] && tmr_age[j] < tmr_age[i]) new_age[i]++;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (gone[i]) tmr_active[i] = 1'b0;
      else if (tmr_active[i]) tmr_age[i] = new_age[i];
    end
  endtask

  // Offer one request, with random idle cycles first
  task automatic send_request(input logic kind, input logic [CB_W-1:0] cb,
                              input logic [TAG_W-1:0] tg, input logic [DUR_W-1:0] dur);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.callback_id = cb;
    in_ch.tag = tg;
    in_ch.duration = dur;
    do @(posedge clk); while (!in_ch.ready);
    predict_timers(kind, cb, tg, dur);
    n_requests++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic arm_timer(input logic [CB_W-1:0] cb, input logic [TAG_W-1:0] tg,
                           input logic [DUR_W-1:0] dur);
    send_request(1'b0, cb, tg, dur);
  endtask

  task automatic tick();
    send_request(1'b1, CB_W'($urandom), TAG_W'($urandom), DUR_W'($urandom));
  endtask

  // Hold until every expected result is in, then let a quiet tick finish
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_tick_div(input logic [MPT_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    tick_div = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Receiver ready, with random stalls and an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Compare each result against the oldest expectation
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", out_ch.result_kind, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_kind !== want.kind)
          report_mismatch("result_kind", out_ch.result_kind, want.kind);
        if (out_ch.fired_callback !== want.cb)
          report_mismatch("fired_callback", out_ch.fired_callback, want.cb);
        if (out_ch.fired_tag !== want.tag)
          report_mismatch("fired_tag", out_ch.fired_tag, want.tag);
        if (out_ch.last !== want.last)
          report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  // Directed: field extremes, immediate fire, short duration, full table, quiet tick
  task automatic test_directed();
    arm_timer(8'hFF, 32'hFFFF_FFFF, '0);
    arm_timer(8'h00, 32'h0, 32'd5);
    tick();
    tick();
    for (int i = 0; i < SLOTS; i++) begin
      if (i < 3) arm_timer(8'(i), 32'hA5A5_0000 + i, 32'hFFFF_FFFF - i);
      else arm_timer(8'(8'hF0 + i), 32'h5A5A_5A5A ^ i, 32'(10 * (i % 4) + 1));
    end
    arm_timer(8'h7E, 32'h1234_5678, 32'd100);
    repeat (5) tick();
    drain();
  endtask

  // Random mix, mostly short timers so that ticks expire them
  task automatic test_random(input int items);
    int span;
    for (int k = 0; k < items; k++) begin
      span = (tick_div == '0) ? 6 : 6 * int'(tick_div);
      if ($urandom_range(0, 99) < 35) tick();
      else if ($urandom_range(0, 99) < 2)
        arm_timer(CB_W'($urandom), TAG_W'($urandom), DUR_W'($urandom));
      else arm_timer(CB_W'($urandom), TAG_W'($urandom), $urandom_range(0, span));
    end
    drain();
  endtask

  // Hold the receiver off long enough for the block to stall its input
  task automatic test_backpressure();
    hold_left = 500;
    for (int k = 0; k < 30; k++) begin
      if (k % 3 == 2) tick();
      else arm_timer(CB_W'($urandom), TAG_W'($urandom),
                     $urandom_range(1, 3 * int'(tick_div)));
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.callback_id = '0;
    in_ch.tag = '0;
    in_ch.duration = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    tick_div = MPT_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tmr_active[i] = 1'b0;
      tmr_left[i] = '0;
      tmr_cb[i] = '0;
      tmr_tag[i] = '0;
      tmr_age[i] = 0;
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle = 19;
    recv_idle = 74;
    test_directed();
    write_tick_div(16'd1);
    test_random(130);
    write_tick_div(16'hFFFF);
    test_random(40);
    send_idle = 74;
    recv_idle = 19;
    write_tick_div(16'd0);
    test_random(100);
    send_idle = 0;
    recv_idle = 0;
    write_tick_div(16'($urandom_range(2, 40)));
    test_backpressure();
    write_tick_div(MPT_RESET);
    test_random(130);

    $display("Covered %0d requests and %0d results (%0d expirations, %0d drops)",
             n_requests, n_results, n_expired, n_dropped);
    $display("over divisors 1, 65535, 0, random and 10, with stalls on both sides");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
